@@ rtl/core/ptrs_pkg.sv @@
// Shared types and constants for the periodic task release scheduler.
package ptrs_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int SLOT_W        = 4;
    localparam int PERIOD_W      = 16;
    localparam int TICK_W        = 32;
    localparam int OPT_W         = 16;
    localparam int REL_SLOT_W    = 3;

    localparam logic [OPT_W-1:0] OPT_RESET = 16'd1;

    localparam logic OP_OVERFLOW = 1'b0;
    localparam logic OP_CREATE   = 1'b1;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic                en;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period;
        logic                valid;
    } tbl_wr_t;

    typedef struct packed {
        logic done;
        logic zero;
    } mod_res_t;

endpackage

@@ rtl/core/ptrs_task_table.sv @@
// Task table: period and valid mark per slot, one write and one read port.
module ptrs_task_table #(
    parameter int MAX_TASKS = ptrs_pkg::MAX_TASKS_DEF,
    parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptrs_pkg::tbl_wr_t             wr,
    input  logic [IDX_W-1:0]              rd_idx,
    output logic [ptrs_pkg::PERIOD_W-1:0] rd_period,
    output logic                          rd_valid
);
    import ptrs_pkg::*;

    logic [PERIOD_W-1:0] period_reg [MAX_TASKS];
    logic [MAX_TASKS-1:0] valid_reg;
    logic                 in_range;

    assign in_range = ({1'b0, wr.slot} < (SLOT_W+1)'(MAX_TASKS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en && in_range)
        begin
            valid_reg[wr.slot[IDX_W-1:0]] <= wr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && in_range)
        begin
            period_reg[wr.slot[IDX_W-1:0]] <= wr.period;
        end
    end

    assign rd_period = period_reg[rd_idx];
    assign rd_valid  = valid_reg[rd_idx];

endmodule

@@ rtl/core/ptrs_mod_serial.sv @@
// Bit-serial restoring modulo: tick count mod period, one dividend bit per cycle.
module ptrs_mod_serial (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ptrs_pkg::TICK_W-1:0]   dividend,
    input  logic [ptrs_pkg::PERIOD_W-1:0] divisor,
    output ptrs_pkg::mod_res_t            res
);
    import ptrs_pkg::*;

    localparam int CNT_W = $clog2(TICK_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TICK_W-1:0]   shift_reg, shift_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] div_reg, div_next;
    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;

    assign trial = {rem_reg, shift_reg[TICK_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[TICK_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[PERIOD_W-1:0];
            end
            else
            begin
                rem_next = trial[PERIOD_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TICK_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign res.done = done_reg;
    assign res.zero = (rem_reg == '0);

endmodule

@@ rtl/core/periodic_task_release_scheduler_unit.sv @@
// Top level of the periodic task release scheduler: control, counters and records.
//
// Create items and overflow beats that do not complete a tick are taken in the idle
// state and busy stays low. A beat that completes a tick raises busy while the task
// table is scanned in slot order: an empty slot or one with period zero is stepped
// over, and a live slot waits for the bit-serial modulo unit, which works through the
// 32-bit tick count one bit per cycle. Records leave one per result_strobe pulse, the
// tick marker first, and cannot be held off; the last record of a tick is on the
// ports in the first cycle with busy low. cfg_ready is always high.
module periodic_task_release_scheduler_unit #(
    parameter int MAX_TASKS = ptrs_pkg::MAX_TASKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            op,
    input  logic [ptrs_pkg::SLOT_W-1:0]     task_slot,
    input  logic [ptrs_pkg::PERIOD_W-1:0]   task_period,
    input  logic                            task_enable,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ptrs_pkg::OPT_W-1:0]      cfg_data,
    output logic                            result_strobe,
    output logic                            record_kind,
    output logic [ptrs_pkg::REL_SLOT_W-1:0] released_slot,
    output logic [ptrs_pkg::TICK_W-1:0]     tick_value,
    output logic                            last
);
    import ptrs_pkg::*;

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    state_t              state_reg, state_next;
    logic [OPT_W-1:0]    opt_reg, opt_next;
    logic [OPT_W-1:0]    cd_reg, cd_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                pend_kind_reg, pend_kind_next;
    logic [SLOT_W-1:0]   pend_slot_reg, pend_slot_next;
    logic                strobe_reg, strobe_next;
    logic                kind_reg, kind_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                last_reg, last_next;

    tbl_wr_t             tbl_wr;
    logic [PERIOD_W-1:0] rd_period;
    logic                rd_valid;
    mod_res_t            mod_res;

    logic accept, tick_hit, scan_done, cand;
    logic div_start, emit, emit_last, step_idx;

    assign accept    = start && (state_reg == ST_IDLE);
    assign tick_hit  = accept && (op == OP_OVERFLOW) && (cd_reg == OPT_W'(1));
    assign scan_done = (idx_reg == CNT_W'(MAX_TASKS));
    assign cand      = rd_valid && (rd_period != '0);

    assign tbl_wr.en     = accept && (op == OP_CREATE);
    assign tbl_wr.slot   = task_slot;
    assign tbl_wr.period = task_period;
    assign tbl_wr.valid  = task_enable;

    ptrs_task_table #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (tbl_wr),
        .rd_idx    (idx_reg[IDX_W-1:0]),
        .rd_period (rd_period),
        .rd_valid  (rd_valid)
    );

    ptrs_mod_serial u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tick_reg),
        .divisor  (rd_period),
        .res      (mod_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_hit)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (scan_done)
                begin
                    state_next = ST_FLUSH;
                end
                else if (cand)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (mod_res.done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        busy      = 1'b1;
        div_start = 1'b0;
        emit      = 1'b0;
        emit_last = 1'b0;
        step_idx  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_LOAD:
            begin
                div_start = !scan_done && cand;
                step_idx  = !scan_done && !cand;
            end
            ST_DIV:
            begin
                emit     = mod_res.done && mod_res.zero;
                step_idx = mod_res.done;
            end
            ST_FLUSH:
            begin
                emit      = 1'b1;
                emit_last = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        opt_next       = opt_reg;
        cd_next        = cd_reg;
        tick_next      = tick_reg;
        idx_next       = idx_reg;
        pend_kind_next = pend_kind_reg;
        pend_slot_next = pend_slot_reg;
        strobe_next    = emit;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        last_next      = emit_last;

        if (cfg_valid)
        begin
            opt_next = cfg_data;
        end

        if (accept && (op == OP_OVERFLOW))
        begin
            if (tick_hit)
            begin
                cd_next        = opt_reg;
                tick_next      = tick_reg + 1'b1;
                idx_next       = '0;
                pend_kind_next = KIND_TICK;
                pend_slot_next = '0;
            end
            else
            begin
                cd_next = cd_reg - 1'b1;
            end
        end

        if (emit)
        begin
            kind_next = pend_kind_reg;
            slot_next = pend_slot_reg;
            if (!emit_last)
            begin
                pend_kind_next = KIND_RELEASE;
                pend_slot_next = SLOT_W'(idx_reg);
            end
        end

        if (step_idx)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            opt_reg    <= OPT_RESET;
            cd_reg     <= OPT_RESET;
            tick_reg   <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            opt_reg    <= opt_next;
            cd_reg     <= cd_next;
            tick_reg   <= tick_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg <= pend_kind_next;
        pend_slot_reg <= pend_slot_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        last_reg      <= last_next;
    end

    assign cfg_ready     = 1'b1;
    assign result_strobe = strobe_reg;
    assign record_kind   = kind_reg;
    assign released_slot = slot_reg[REL_SLOT_W-1:0];
    assign tick_value    = tick_reg;
    assign last          = last_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        mod_res.done |-> (state_reg == ST_DIV))
        else $error("modulo result outside scan");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |=> (result_strobe && last))
        else $error("flush without closing record");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |=> !result_strobe)
        else $error("record after closing beat");

endmodule
